// File: sv/skel_pkg.sv
// ----------------------------------------------------------------------------
// Skeleton pixel classifier package
// Shared widths, codes, the job and result records and the window labeling
// function used by the front and back parts of the classifier.
// ----------------------------------------------------------------------------
package skel_pkg;

  // Default sizes of the frame storage and the job queue.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Field widths.
  localparam int PIXEL_W        = 8;
  localparam int COL_W          = 10;
  localparam int ROW_W          = 12;
  localparam int LABEL_W        = 3;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int MATCH_W        = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  // Stream widths.
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 3;

  // Register reset values.
  localparam int                 FRAME_WIDTH_RST  = 1024;
  localparam int                 FRAME_HEIGHT_RST = 1024;
  localparam logic [MATCH_W-1:0] MATCH_RST        = 8'd255;

  // Window layout: three columns, oldest in the low bits. Each column holds
  // three rows of two-bit cells, the row two above in the low bits. Bit 0 of
  // a cell is "on", bit 1 is "equal to the match value".
  localparam int CELL_W     = 2;
  localparam int WIN_ROWS   = 3;
  localparam int WIN_COLS   = 3;
  localparam int WIN_COL_W  = CELL_W * WIN_ROWS;
  localparam int WIN_W      = WIN_COL_W * WIN_COLS;
  localparam int LINE_W     = 2 * CELL_W;
  localparam int COUNT_W    = 4;

  // Result slots of one job, in delivery order.
  localparam int NUM_SLOTS    = 4;
  localparam int SLOT_IDX_W   = 2;
  localparam int SLOT_UP_LEFT  = 0;  // row above, column to the left
  localparam int SLOT_UP_EDGE  = 1;  // row above, last column
  localparam int SLOT_LOW_LEFT = 2;  // last row, column to the left
  localparam int SLOT_LOW_EDGE = 3;  // last row, last column

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MATCH_VALUE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [LABEL_W-1:0] {
    LBL_BLANK    = 3'd0,
    LBL_LINE     = 3'd1,
    LBL_ENDPOINT = 3'd2,
    LBL_JUNCTION = 3'd3,
    LBL_DOT      = 3'd4
  } label_e;

  // One window snapshot with the results it owes.
  typedef struct packed {
    logic [WIN_W-1:0]     win;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [NUM_SLOTS-1:0] slots;
  } job_t;

  // One labeled pixel.
  typedef struct packed {
    logic             frame_last;
    logic             run_last;
    logic             node_pixel;
    logic             connection_pixel;
    label_e           label;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } result_t;

  // Labels the cell at (cr, cc) of the window from the match count of its
  // 3x3 neighborhood; cells outside the window count as absent.
  function automatic label_e classify(input logic [WIN_W-1:0] win,
                                      input logic [1:0] cr,
                                      input logic [1:0] cc);
    logic [COUNT_W-1:0] cnt;
    int                 rr;
    int                 kk;
    int                 dr;
    int                 dc;
    label_e             lbl;
    cnt = '0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        rr = int'(cr) + dr;
        kk = int'(cc) + dc;
        if (rr >= 0 && rr < WIN_ROWS && kk >= 0 && kk < WIN_COLS) begin
          cnt = cnt + COUNT_W'(win[kk * WIN_COL_W + rr * CELL_W + 1]);
        end
      end
    end
    if (!win[int'(cc) * WIN_COL_W + int'(cr) * CELL_W]) begin
      lbl = LBL_BLANK;
    end else if (cnt == COUNT_W'(3)) begin
      lbl = LBL_LINE;
    end else if (cnt == COUNT_W'(2)) begin
      lbl = LBL_ENDPOINT;
    end else if (cnt > COUNT_W'(3)) begin
      lbl = LBL_JUNCTION;
    end else begin
      lbl = LBL_DOT;
    end
    return lbl;
  endfunction

endpackage

// File: sv/skel_front.sv
// ----------------------------------------------------------------------------
// Skeleton classifier front part
// Takes pixels, keeps the two rows above in a line memory and the 3x3 window
// in registers, and hands each window that owes results to the job queue.
// ----------------------------------------------------------------------------
module skel_front #(
  parameter int  MAX_WIDTH  = skel_pkg::MAX_WIDTH_DEF,
  parameter int  MAX_HEIGHT = skel_pkg::MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [skel_pkg::PIXEL_W-1:0]   pixel_i,
  input  logic [CW-1:0]                  last_col_i,
  input  logic [RW-1:0]                  last_row_i,
  input  logic [skel_pkg::MATCH_W-1:0]   match_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output skel_pkg::job_t                 job_o
);
  import skel_pkg::*;

  // Line memory entry: row two above in the high cell, row above in the low.
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];

  logic              a_accept;
  logic              a_row_end;
  logic              a_last_row;
  logic [CELL_W-1:0] a_cur;
  logic [CW-1:0]     col_cnt_q;
  logic [RW-1:0]     row_cnt_q;

  logic              b_valid_q;
  logic              b_go;
  logic [CW-1:0]     b_col_q;
  logic [RW-1:0]     b_row_q;
  logic [CELL_W-1:0] b_cur_q;
  logic              b_row_end_q;
  logic              b_last_row_q;
  logic [LINE_W-1:0] rd_q;
  logic              fwd_q;
  logic [LINE_W-1:0] fwd_data_q;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] wr_data;
  logic [CELL_W-1:0] nb;
  logic [CELL_W-1:0] fb;
  logic [WIN_W-1:0]  win_q;
  logic [WIN_W-1:0]  win_base;
  logic [WIN_W-1:0]  win_d;
  logic              col_nz;
  logic              row_nz;
  logic [NUM_SLOTS-1:0] slots;

  // Position and classification of the incoming pixel.
  assign a_accept   = s_valid_i && s_ready_o;
  assign a_row_end  = col_cnt_q >= last_col_i;
  assign a_last_row = row_cnt_q >= last_row_i;
  assign a_cur      = {pixel_i == match_i, pixel_i != '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (a_accept) begin
      if (a_row_end) begin
        col_cnt_q <= '0;
        row_cnt_q <= a_last_row ? '0 : row_cnt_q + RW'(1);
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end
  end

  // The window stage advances when its job is taken or owes nothing.
  assign job_valid_o = b_valid_q && (|slots);
  assign b_go        = b_valid_q && (!(|slots) || job_ready_i);
  assign s_ready_o   = !b_valid_q || b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      if (a_accept) begin
        b_valid_q <= 1'b1;
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
      if (b_go) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_accept) begin
      b_col_q      <= col_cnt_q;
      b_row_q      <= row_cnt_q;
      b_cur_q      <= a_cur;
      b_row_end_q  <= a_row_end;
      b_last_row_q <= a_last_row;
      // A one-column frame reads the entry that the stage ahead writes now.
      fwd_q        <= b_go && (b_col_q == col_cnt_q);
      fwd_data_q   <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      line_mem[b_col_q] <= wr_data;
    end
    if (a_accept) begin
      rd_q <= line_mem[col_cnt_q];
    end
  end

  always_comb begin
    line     = fwd_q ? fwd_data_q : rd_q;
    wr_data  = {line[CELL_W-1:0], b_cur_q};
    row_nz   = b_row_q != '0;
    col_nz   = b_col_q != '0;
    nb       = row_nz ? line[CELL_W-1:0] : '0;
    fb       = (b_row_q > RW'(1)) ? line[LINE_W-1:CELL_W] : '0;
    win_base = col_nz ? win_q : '0;
    win_d    = {b_cur_q, nb, fb, win_base[WIN_W-1:WIN_COL_W]};

    slots                = '0;
    slots[SLOT_UP_LEFT]  = row_nz && col_nz;
    slots[SLOT_UP_EDGE]  = row_nz && b_row_end_q;
    slots[SLOT_LOW_LEFT] = b_last_row_q && col_nz;
    slots[SLOT_LOW_EDGE] = b_last_row_q && b_row_end_q;

    job_o.win   = win_d;
    job_o.col   = COL_W'(b_col_q);
    job_o.row   = ROW_W'(b_row_q);
    job_o.slots = slots;
  end

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_go |=> b_valid_q && $stable(b_col_q) && $stable(b_cur_q))
    else $error("window stage changed while stalled");

endmodule

// File: sv/skel_fifo.sv
// ----------------------------------------------------------------------------
// Skeleton classifier job queue
// A short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module skel_fifo #(
  parameter int  DEPTH = skel_pkg::QUEUE_DEPTH_DEF,
  localparam int PW    = $clog2(DEPTH),
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  skel_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output skel_pkg::job_t pop_data_o
);
  import skel_pkg::*;

  job_t          slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = cnt_q != NW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH))
    else $error("job queue fill count out of range");

endmodule

// File: sv/skel_back.sv
// ----------------------------------------------------------------------------
// Skeleton classifier back part
// Works through the result slots of each job, labels one pixel per beat and
// holds it in the output register.
// ----------------------------------------------------------------------------
module skel_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  skel_pkg::job_t    job_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output skel_pkg::result_t res_o
);
  import skel_pkg::*;

  job_t                  job_q;
  logic                  job_valid_q;
  logic [NUM_SLOTS-1:0]  pend_q;
  logic [NUM_SLOTS-1:0]  pend_rest;
  logic [SLOT_IDX_W-1:0] sel_idx;
  logic                  out_valid_q;
  result_t               out_q;
  result_t               res_d;
  logic                  out_free;
  logic                  fire;
  logic                  done;
  logic                  load;
  logic [1:0]            cr;
  logic [1:0]            cc;

  // Lowest pending slot goes first.
  always_comb begin
    sel_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx = SLOT_IDX_W'(i);
      end
    end
  end

  assign pend_rest   = pend_q & ~(NUM_SLOTS'(1) << sel_idx);
  assign out_free    = !out_valid_q || res_ready_i;
  assign fire        = job_valid_q && out_free;
  assign done        = fire && (pend_rest == '0);
  assign job_ready_o = !job_valid_q || done;
  assign load        = job_ready_o && job_valid_i;

  always_comb begin
    // Upper slots center on the row above, edge slots on the newest column.
    cr = sel_idx[1] ? 2'd2 : 2'd1;
    cc = sel_idx[0] ? 2'd2 : 2'd1;
    res_d.label            = classify(job_q.win, cr, cc);
    res_d.col              = sel_idx[0] ? job_q.col : job_q.col - COL_W'(1);
    res_d.row              = sel_idx[1] ? job_q.row : job_q.row - ROW_W'(1);
    res_d.connection_pixel = (res_d.label == LBL_LINE) || (res_d.label == LBL_ENDPOINT);
    res_d.node_pixel       = (res_d.label == LBL_ENDPOINT) || (res_d.label == LBL_JUNCTION);
    res_d.run_last         = pend_rest == '0;
    res_d.frame_last       = sel_idx == SLOT_IDX_W'(SLOT_LOW_EDGE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        job_valid_q <= 1'b1;
        pend_q      <= job_i.slots;
      end else if (done) begin
        job_valid_q <= 1'b0;
        pend_q      <= '0;
      end else if (fire) begin
        pend_q <= pend_rest;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_job_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> pend_q != '0)
    else $error("held job has no pending result");

  a_frame_end_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_last |-> out_q.run_last)
    else $error("frame end result is not the last of its run");

endmodule

// File: sv/skeleton_pixel_classifier.sv
// ----------------------------------------------------------------------------
// Skeleton pixel classifier
// Labels each pixel of a thinned skeleton as blank, line, endpoint, junction
// or isolated dot from the match count of its 3x3 neighborhood.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+------------------------------------------------------
//  s_axis  | in        | tdata[7:0] pixel
//  m_axis  | out       | tdata col, row, label; tuser flags; tlast run end
//  cfg     | in        | cfg_index_i register, cfg_data_i value
//
//  The block takes one pixel per clock while its window stage is not held
//  by a full job queue. Each pixel is labeled once the pixel below and to
//  the right of it has arrived, so results trail the input by one row and
//  one pixel. Results leave at one per clock while the output is ready.
//  Inside a frame each pixel gives at most two results (two only at a row
//  end, none at the next row start); on the last row each pixel after the
//  first gives two and the row end gives four, so the output port sets the
//  pace there and the four-entry job queue absorbs the difference before
//  the input stalls.
//  The two rows above live in one line memory of MAX_WIDTH entries with one
//  read and one write port. Reset needs no clearing pass: rows above the top
//  of the frame are masked, so the block is ready right after reset.
//  The user must write configuration only while the block is idle; the block does not enforce it.
//
module skeleton_pixel_classifier #(
  parameter int MAX_WIDTH   = skel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = skel_pkg::MAX_HEIGHT_DEF,
  parameter int QUEUE_DEPTH = skel_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Pixel input. tdata: [7:0] pixel.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [skel_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // Labeled pixels. tdata: [9:0] col, [21:10] row, [24:22] label, rest zero.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [skel_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // tuser: [0] connection_pixel, [1] node_pixel, [2] frame_last.
  output logic [skel_pkg::M_TUSER_W-1:0]    m_axis_tuser_o,
  // tlast: last result caused by one input pixel.
  output logic                              m_axis_tlast_o,
  // Register writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [skel_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [skel_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import skel_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Registers hold the last column and row index of a frame, with the size
  // already clamped to the supported range.
  localparam logic [CW-1:0] LAST_COL_RST =
    CW'(((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST) - 1);
  localparam logic [RW-1:0] LAST_ROW_RST =
    RW'(((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST) - 1);

  logic [CW-1:0]             last_col_q;
  logic [CW-1:0]             last_col_d;
  logic [RW-1:0]             last_row_q;
  logic [RW-1:0]             last_row_d;
  logic [MATCH_W-1:0]        match_q;
  logic [FRAME_WIDTH_W-1:0]  w_in;
  logic [FRAME_HEIGHT_W-1:0] h_in;
  logic                      cfg_write;

  logic    job_push_valid;
  logic    job_push_ready;
  job_t    job_push;
  logic    job_pop_valid;
  logic    job_pop_ready;
  job_t    job_pop;
  result_t res;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign w_in        = cfg_data_i[FRAME_WIDTH_W-1:0];
  assign h_in        = cfg_data_i[FRAME_HEIGHT_W-1:0];

  // A size of zero acts as one; a size above the storage acts as its limit.
  always_comb begin
    if (w_in == '0) begin
      last_col_d = '0;
    end else if (32'(w_in) > 32'(MAX_WIDTH)) begin
      last_col_d = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_d = CW'(w_in - FRAME_WIDTH_W'(1));
    end
    if (h_in == '0) begin
      last_row_d = '0;
    end else if (32'(h_in) > 32'(MAX_HEIGHT)) begin
      last_row_d = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_d = RW'(h_in - FRAME_HEIGHT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= LAST_COL_RST;
      last_row_q <= LAST_ROW_RST;
      match_q    <= MATCH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  last_col_q <= last_col_d;
        CFG_FRAME_HEIGHT: last_row_q <= last_row_d;
        CFG_MATCH_VALUE:  match_q    <= cfg_data_i[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  skel_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .pixel_i     (s_axis_tdata_i[PIXEL_W-1:0]),
    .last_col_i  (last_col_q),
    .last_row_i  (last_row_q),
    .match_i     (match_q),
    .job_valid_o (job_push_valid),
    .job_ready_i (job_push_ready),
    .job_o       (job_push)
  );

  skel_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_push_valid),
    .push_ready_o (job_push_ready),
    .push_data_i  (job_push),
    .pop_valid_o  (job_pop_valid),
    .pop_ready_i  (job_pop_ready),
    .pop_data_o   (job_pop)
  );

  skel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_pop_valid),
    .job_ready_o (job_pop_ready),
    .job_i       (job_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result beat.
  assign m_axis_tdata_o = {(M_TDATA_W - COL_W - ROW_W - LABEL_W)'(0),
                           res.label, res.row, res.col};
  assign m_axis_tuser_o = {res.frame_last, res.node_pixel, res.connection_pixel};
  assign m_axis_tlast_o = res.run_last;

endmodule
